>>> src/sce_pkg.sv
`timescale 1ns / 1ps

package sce_pkg;

  localparam int PROB_BITS = 16;
  localparam int DATA_W    = 16;
  localparam int TGT_W     = 5;
  localparam int LOSS_W    = 24;
  localparam int CNT_W     = 7;
  localparam int E_W       = 31;
  localparam int ESUM_W    = 37;
  localparam int LSUM_W    = 40;
  localparam int DVD_W     = 48;
  localparam int DVS_W     = 37;
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 33;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam logic [E_W-1:0]    ONE_Q30      = 31'h4000_0000;
  localparam logic [29:0]       LN2_Q30      = 30'd744261118;
  localparam logic [16:0]       LOG2E_Q16    = 17'd94548;
  localparam logic [LOSS_W-1:0] EPS_LOSS_Q16 = 24'd1358120;
  localparam logic [LOSS_W-1:0] LOSS_MAX     = 24'hFF_FFFF;
  localparam logic [LSUM_W-1:0] SUM_MAX      = 40'hFF_FFFF_FFFF;
  localparam logic [20:0]       PROB_LOG_Q16 = 21'(PROB_BITS << 16);

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_ROW_LONG   = 2'd1;
  localparam logic [1:0] STATUS_BAD_TARGET = 2'd2;

  typedef enum logic [0:0] {
    REG_BATCH_SIZE = 1'b0,
    REG_UPSTREAM   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] logit;
    logic [TGT_W-1:0]         target_class;
    logic                     last_in_row;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gradient;
    logic [TGT_W-1:0]         class_index;
    logic [LOSS_W-1:0]        row_loss;
    logic [LOSS_W-1:0]        mean_loss;
    logic                     mean_valid;
    logic                     last_of_row;
    logic [1:0]               status;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [TGT_W-1:0] target;
    logic             overflow;
  } desc_t;

  // floor(2^32 / k), exact 2^32 for k = 1
  function automatic logic [MUL_B_W-1:0] recip(input logic [3:0] k);
    logic [MUL_B_W-1:0] r;
    case (k)
      4'd1:    r = 33'h1_0000_0000;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> src/sce_div.sv
`timescale 1ns / 1ps

module sce_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sce_pkg::DVD_W-1:0]  dividend_i,
  input  logic [sce_pkg::DVS_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [sce_pkg::DVD_W-1:0]  quotient_o
);
  import sce_pkg::*;

  localparam int CW = $clog2(DVD_W);

  logic [DVS_W:0]   rem_q, rem_sh;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             ge;

  assign rem_sh = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      dvs_q  <= divisor_i;
      cnt_q  <= CW'(DVD_W - 1);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      // one quotient bit per cycle, restoring
      rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_q <= {quo_q[DVD_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

>>> src/sce_front.sv
`timescale 1ns / 1ps

module sce_front #(
  parameter int MAX_CLASSES = 32,
  localparam int IW = $clog2(MAX_CLASSES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  sce_pkg::in_t                in_data_i,
  output logic                        desc_valid_o,
  output sce_pkg::desc_t              desc_o,
  output logic                        desc_bank_o,
  input  logic                        desc_pop_i,
  input  logic [IW:0]                 lg_raddr_i,
  output logic signed [sce_pkg::DATA_W-1:0] lg_rdata_o
);
  import sce_pkg::*;

  localparam int CW    = $clog2(MAX_CLASSES + 1);
  localparam int DEPTH = 2 * (2 ** IW);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  logic [CW-1:0] cnt_q;
  logic          ovf_q;
  desc_t         desc_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    q_cnt_q;
  logic          accept, push, room;
  logic [CW-1:0] cnt_after;
  logic          ovf_after;

  assign in_ready_o = q_cnt_q != 2'd2;
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && in_data_i.last_in_row;
  assign room       = cnt_q < CW'(MAX_CLASSES);
  assign cnt_after  = room ? cnt_q + 1'b1 : cnt_q;
  assign ovf_after  = ovf_q || !room;

  always_ff @(posedge clk_i) begin
    if (accept && room) begin
      mem[{wr_ptr_q, cnt_q[IW-1:0]}] <= in_data_i.logit;
    end
    rdata_q <= mem[lg_raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      q_cnt_q  <= '0;
      desc_q[0] <= '0;
      desc_q[1] <= '0;
    end else begin
      if (accept) begin
        if (in_data_i.last_in_row) begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
          desc_q[wr_ptr_q] <= '{count:    CNT_W'(cnt_after),
                                target:   in_data_i.target_class,
                                overflow: ovf_after};
          wr_ptr_q <= !wr_ptr_q;
        end else begin
          cnt_q <= cnt_after;
          ovf_q <= ovf_after;
        end
      end
      if (desc_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, desc_pop_i};
    end
  end

  assign desc_valid_o = q_cnt_q != 2'd0;
  assign desc_o       = desc_q[rd_ptr_q];
  assign desc_bank_o  = rd_ptr_q;
  assign lg_rdata_o   = rdata_q;

endmodule

>>> src/sce_back.sv
`timescale 1ns / 1ps

module sce_back #(
  parameter int MAX_CLASSES = 32,
  localparam int IW = $clog2(MAX_CLASSES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        desc_valid_i,
  input  sce_pkg::desc_t              desc_i,
  input  logic                        desc_bank_i,
  output logic                        desc_pop_o,
  output logic [IW:0]                 lg_raddr_o,
  input  logic signed [sce_pkg::DATA_W-1:0] lg_rdata_i,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [15:0]                 cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sce_pkg::out_t               out_data_o
);
  import sce_pkg::*;

  localparam int CW = $clog2(MAX_CLASSES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MX_RD, S_MX_CMP,
    S_EX_RD, S_EX_Y, S_EX_Z, S_EX_U, S_EX_M1, S_EX_M2, S_EX_M3, S_EX_WR,
    S_PR_RD, S_PR_DIV, S_PR_WAIT,
    S_LS, S_LG_NORM, S_LG_SQ, S_LG_ST, S_LG_LN, S_LG_RND,
    S_ACC, S_CHK, S_MN_WAIT,
    S_GR_RD, S_GR_MUL, S_GR_DIV, S_GR_WAIT
  } state_e;

  state_e state_q;

  logic [15:0]              batch_q;
  logic signed [15:0]       up_q;
  logic [15:0]              batch_eff;

  logic [CW-1:0]            n_q, c_q;
  logic [TGT_W-1:0]         tgt_q;
  logic                     ovf_q, bank_q;
  logic signed [DATA_W-1:0] mx_q;
  logic [ESUM_W-1:0]        sum_q;
  logic [5:0]               nsh_q;
  logic [29:0]              u_q, v_q;
  logic [E_W-1:0]           r_q;
  logic [3:0]               k_q;
  logic [15:0]              p_tgt_q, m16_q;
  logic [3:0]               nbit_q;
  logic [E_W-1:0]           m_q;
  logic [15:0]              fr_q;
  logic [4:0]               i_q;
  logic [LOSS_W-1:0]        rloss_q, mean_q;
  logic                     mvalid_q;
  logic [LSUM_W-1:0]        lsum_q;
  logic [15:0]              rows_q;
  logic                     gsign_q;
  logic [PROD_W-1:0]        prod_q;
  out_t                     out_q;
  logic                     out_valid_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  logic [E_W-1:0] wk_mem [2 ** IW];
  logic [E_W-1:0] wk_rdata_q;
  logic           wk_we;
  logic [E_W-1:0] wk_wdata;

  logic             div_start, div_busy;
  logic [DVD_W-1:0] div_dvd, div_quo;
  logic [DVS_W-1:0] div_dvs;

  logic              last_c, tgt_ok, hot, out_load;
  logic [1:0]        status;
  logic [16:0]       y_diff;
  logic [29:0]       q0, qf;
  logic [33:0]       qk, qrem;
  logic [E_W-1:0]    e_val;
  logic [15:0]       p_val;
  logic [31:0]       sq;
  logic [20:0]       neg_log;
  logic [51:0]       loss_rnd;
  logic [LSUM_W:0]   lsum_add;
  logic [16:0]       mag_u, mag_d;
  logic signed [DATA_W-1:0] grad;
  logic [LOSS_W-1:0] mean_sat;

  sce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign batch_eff = (batch_q == '0) ? 16'd1 : batch_q;
  assign last_c    = c_q == n_q - 1'b1;
  assign tgt_ok    = 8'(tgt_q) < 8'(n_q);
  assign hot       = tgt_ok && (8'(c_q) == 8'(tgt_q));
  assign status    = !tgt_ok ? STATUS_BAD_TARGET : (ovf_q ? STATUS_ROW_LONG : STATUS_OK);

  // exp series: divide by k through a reciprocal, then fix the low-by-one case
  assign y_diff = {mx_q[DATA_W-1], mx_q} - {lg_rdata_i[DATA_W-1], lg_rdata_i};
  assign q0     = prod_q[61:32];
  assign qk     = 34'(q0) * 34'(k_q);
  assign qrem   = 34'(v_q) - qk;
  assign qf     = (qrem >= 34'(k_q)) ? q0 + 1'b1 : q0;
  assign e_val  = (nsh_q > 6'd30) ? '0 : (r_q >> nsh_q);

  assign p_val    = (div_quo > DVD_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
  assign sq       = prod_q[61:30];
  assign neg_log  = PROB_LOG_Q16 - {1'b0, nbit_q, fr_q};
  assign loss_rnd = prod_q[51:0] + 52'(1 << 29);
  assign lsum_add = {1'b0, lsum_q} + (LSUM_W + 1)'(rloss_q);
  assign mean_sat = (div_quo > DVD_W'(LOSS_MAX)) ? LOSS_MAX : div_quo[LOSS_W-1:0];

  assign mag_u = up_q[15] ? 17'(-{up_q[15], up_q}) : {1'b0, up_q};
  assign mag_d = hot ? (17'h1_0000 - {1'b0, wk_rdata_q[15:0]}) : {1'b0, wk_rdata_q[15:0]};

  always_comb begin
    if (gsign_q) begin
      grad = (div_quo > DVD_W'(32768)) ? 16'sh8000 : DATA_W'(-div_quo[15:0]);
    end else begin
      grad = (div_quo > DVD_W'(32767)) ? 16'sh7FFF : div_quo[15:0];
    end
  end

  // one shared multiplier, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_EX_Y: begin
        mul_a = MUL_A_W'(y_diff[15:0]);
        mul_b = MUL_B_W'(LOG2E_Q16);
      end
      S_EX_Z: begin
        mul_a = MUL_A_W'(prod_q[26:0]);
        mul_b = MUL_B_W'(LN2_Q30);
      end
      S_EX_M1: begin
        mul_a = MUL_A_W'(u_q);
        mul_b = MUL_B_W'(r_q);
      end
      S_EX_M2: begin
        mul_a = MUL_A_W'(prod_q[59:30]);
        mul_b = recip(k_q);
      end
      S_LG_SQ: begin
        mul_a = MUL_A_W'(m_q);
        mul_b = MUL_B_W'(m_q);
      end
      S_LG_LN: begin
        mul_a = MUL_A_W'(neg_log);
        mul_b = MUL_B_W'(LN2_Q30);
      end
      S_GR_MUL: begin
        mul_a = MUL_A_W'(mag_u);
        mul_b = MUL_B_W'(mag_d);
      end
      default: ;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state_q)
      S_PR_DIV: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({wk_rdata_q, 16'b0}) + DVD_W'(sum_q >> 1);
        div_dvs   = DVS_W'(sum_q);
      end
      S_CHK: begin
        div_start = 17'(rows_q) >= 17'(batch_eff);
        div_dvd   = DVD_W'(lsum_q) + DVD_W'(batch_eff >> 1);
        div_dvs   = DVS_W'(batch_eff);
      end
      S_GR_DIV: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(prod_q[32:0]) + DVD_W'({batch_eff, 12'b0});
        div_dvs   = DVS_W'({batch_eff, 13'b0});
      end
      default: ;
    endcase
  end

  always_comb begin
    wk_we    = 1'b0;
    wk_wdata = e_val;
    if (state_q == S_EX_WR) begin
      wk_we = 1'b1;
    end else if (state_q == S_PR_WAIT && !div_busy) begin
      wk_we    = 1'b1;
      wk_wdata = E_W'(p_val);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wk_we) begin
      wk_mem[c_q[IW-1:0]] <= wk_wdata;
    end
    wk_rdata_q <= wk_mem[c_q[IW-1:0]];
    prod_q     <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign lg_raddr_o = {bank_q, c_q[IW-1:0]};
  assign desc_pop_o = state_q == S_EX_WR && last_c;
  assign out_load   = state_q == S_GR_WAIT && !div_busy && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      batch_q     <= 16'd1;
      up_q        <= 16'sd256;
      n_q         <= '0;
      c_q         <= '0;
      tgt_q       <= '0;
      ovf_q       <= 1'b0;
      bank_q      <= 1'b0;
      mx_q        <= '0;
      sum_q       <= '0;
      nsh_q       <= '0;
      u_q         <= '0;
      v_q         <= '0;
      r_q         <= '0;
      k_q         <= '0;
      p_tgt_q     <= '0;
      m16_q       <= '0;
      nbit_q      <= '0;
      m_q         <= '0;
      fr_q        <= '0;
      i_q         <= '0;
      rloss_q     <= '0;
      mean_q      <= '0;
      mvalid_q    <= 1'b0;
      lsum_q      <= '0;
      rows_q      <= '0;
      gsign_q     <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_BATCH_SIZE: batch_q <= cfg_data_i;
          REG_UPSTREAM:   up_q    <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (desc_valid_i) begin
            n_q     <= CW'(desc_i.count);
            tgt_q   <= desc_i.target;
            ovf_q   <= desc_i.overflow;
            bank_q  <= desc_bank_i;
            c_q     <= '0;
            state_q <= S_MX_RD;
          end
        end
        S_MX_RD: state_q <= S_MX_CMP;
        S_MX_CMP: begin
          if (c_q == '0 || lg_rdata_i > mx_q) begin
            mx_q <= lg_rdata_i;
          end
          if (last_c) begin
            c_q     <= '0;
            sum_q   <= '0;
            state_q <= S_EX_RD;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= S_MX_RD;
          end
        end
        S_EX_RD: state_q <= S_EX_Y;
        S_EX_Y:  state_q <= S_EX_Z;
        S_EX_Z: begin
          nsh_q   <= prod_q[32:27];
          state_q <= S_EX_U;
        end
        S_EX_U: begin
          u_q     <= prod_q[56:27];
          r_q     <= ONE_Q30;
          k_q     <= 4'd8;
          state_q <= S_EX_M1;
        end
        S_EX_M1: state_q <= S_EX_M2;
        S_EX_M2: begin
          v_q     <= prod_q[59:30];
          state_q <= S_EX_M3;
        end
        S_EX_M3: begin
          r_q <= ONE_Q30 - E_W'(qf);
          if (k_q == 4'd1) begin
            state_q <= S_EX_WR;
          end else begin
            k_q     <= k_q - 1'b1;
            state_q <= S_EX_M1;
          end
        end
        S_EX_WR: begin
          sum_q <= sum_q + ESUM_W'(e_val);
          if (last_c) begin
            c_q     <= '0;
            state_q <= S_PR_RD;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= S_EX_RD;
          end
        end
        S_PR_RD:  state_q <= S_PR_DIV;
        S_PR_DIV: state_q <= S_PR_WAIT;
        S_PR_WAIT: begin
          if (!div_busy) begin
            if (hot) begin
              p_tgt_q <= p_val;
            end
            if (last_c) begin
              state_q <= S_LS;
            end else begin
              c_q     <= c_q + 1'b1;
              state_q <= S_PR_RD;
            end
          end
        end
        S_LS: begin
          if (!tgt_ok) begin
            rloss_q <= '0;
            state_q <= S_ACC;
          end else if (p_tgt_q == '0) begin
            rloss_q <= EPS_LOSS_Q16;
            state_q <= S_ACC;
          end else begin
            m16_q   <= p_tgt_q;
            nbit_q  <= 4'd15;
            state_q <= S_LG_NORM;
          end
        end
        S_LG_NORM: begin
          if (m16_q[15]) begin
            m_q     <= {m16_q, 15'b0};
            fr_q    <= '0;
            i_q     <= 5'd16;
            state_q <= S_LG_SQ;
          end else begin
            m16_q  <= m16_q << 1;
            nbit_q <= nbit_q - 1'b1;
          end
        end
        S_LG_SQ: state_q <= S_LG_ST;
        S_LG_ST: begin
          // square, then renormalize into [1, 2)
          fr_q <= {fr_q[14:0], sq[31]};
          m_q  <= sq[31] ? sq[31:1] : sq[30:0];
          if (i_q == 5'd1) begin
            state_q <= S_LG_LN;
          end else begin
            i_q     <= i_q - 1'b1;
            state_q <= S_LG_SQ;
          end
        end
        S_LG_LN: state_q <= S_LG_RND;
        S_LG_RND: begin
          rloss_q <= LOSS_W'(loss_rnd[51:30]);
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (tgt_ok) begin
            lsum_q <= (lsum_add > (LSUM_W + 1)'(SUM_MAX)) ? SUM_MAX : lsum_add[LSUM_W-1:0];
          end
          rows_q  <= rows_q + 1'b1;
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (div_start) begin
            state_q <= S_MN_WAIT;
          end else begin
            mean_q   <= '0;
            mvalid_q <= 1'b0;
            c_q      <= '0;
            state_q  <= S_GR_RD;
          end
        end
        S_MN_WAIT: begin
          if (!div_busy) begin
            mean_q   <= mean_sat;
            mvalid_q <= 1'b1;
            lsum_q   <= '0;
            rows_q   <= '0;
            c_q      <= '0;
            state_q  <= S_GR_RD;
          end
        end
        S_GR_RD: state_q <= S_GR_MUL;
        S_GR_MUL: begin
          gsign_q <= hot ^ up_q[15];
          state_q <= S_GR_DIV;
        end
        S_GR_DIV: state_q <= S_GR_WAIT;
        S_GR_WAIT: begin
          if (out_load) begin
            out_q <= '{gradient:    grad,
                       class_index: TGT_W'(c_q),
                       row_loss:    rloss_q,
                       mean_loss:   mean_q,
                       mean_valid:  mvalid_q,
                       last_of_row: last_c,
                       status:      status};
            if (last_c) begin
              state_q <= S_IDLE;
            end else begin
              c_q     <= c_q + 1'b1;
              state_q <= S_GR_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_pop_o |-> desc_valid_i)
    else $error("row descriptor popped from empty queue");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (c_q < n_q))
    else $error("gradient class beyond row length");

  a_batch_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MN_WAIT && !div_busy) |=> (rows_q == '0 && lsum_q == '0))
    else $error("loss sum not cleared after batch mean");
`endif

endmodule

>>> src/softmax_cross_entropy_loss_grad.sv
`timescale 1ns / 1ps
// Loading: the front end takes one logit per cycle while in_ready_o is high. After a row's
// last logit the back end finds the max, exps, probabilities, loss, mean and gradients,
// using a bit-serial divider and the eight-term exp series on one shared 32x33 multiplier.
// Throughput: rows are processed one at a time; a second row may load while one is computed.
// Reset clears all control state, batch_size to 1 and upstream_gradient to 1.0 (Q8.8);
// logit and probability stores are not cleared and need no clearing pass.
module softmax_cross_entropy_loss_grad #(
  parameter int MAX_CLASSES = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sce_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sce_pkg::out_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic [0:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i
);
  import sce_pkg::*;

  localparam int IW = $clog2(MAX_CLASSES);

  logic                     desc_valid, desc_bank, desc_pop;
  desc_t                    desc;
  logic [IW:0]              lg_raddr;
  logic signed [DATA_W-1:0] lg_rdata;

  sce_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .desc_valid_o (desc_valid),
    .desc_o       (desc),
    .desc_bank_o  (desc_bank),
    .desc_pop_i   (desc_pop),
    .lg_raddr_i   (lg_raddr),
    .lg_rdata_o   (lg_rdata)
  );

  sce_back #(.MAX_CLASSES(MAX_CLASSES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .desc_bank_i  (desc_bank),
    .desc_pop_o   (desc_pop),
    .lg_raddr_o   (lg_raddr),
    .lg_rdata_i   (lg_rdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import sce_pkg::*;

  localparam int NCLS = 32;
  localparam int LIMIT_CYCLES = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = REG_BATCH_SIZE;
  logic [15:0] cfg_data_i = '0;

  softmax_cross_entropy_loss_grad DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // model state
  logic signed [15:0] row_logits [NCLS];
  logic [5:0] nlogits;
  logic too_long;
  logic [39:0] sum_loss;
  logic [15:0] rows_in_batch;
  logic [15:0] batch_reg;
  logic signed [15:0] upstream_reg;

  out_t grad_queue[$];
  int errors = 0;
  int results_seen = 0;
  int rows_sent = 0;
  int items_sent = 0;
  int cycles = 0;
  int send_idle = 28;
  int recv_idle = 80;

  task automatic report(input string what, input out_t got, input out_t want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic logic [63:0] exp_q30(input logic [31:0] y);
    logic [63:0] z, n, f, u, r;
    z = 64'(y) * 64'(LOG2E_Q16);
    n = z >> 27;
    f = z & ((64'd1 << 27) - 1);
    u = (f * 64'(LN2_Q30)) >> 27;
    r = 64'd1 << 30;
    for (int k = 8; k >= 1; k--) r = (64'd1 << 30) - ((u * r) >> 30) / 64'(k);
    return (n > 30) ? 64'd0 : (r >> n);
  endfunction

  function automatic logic [63:0] loss_of_prob(input logic [31:0] p);
    int msb;
    logic [63:0] m, fr, neg, l;
    if (p == 0) return 64'(EPS_LOSS_Q16);
    msb = 31;
    while (msb > 0 && p[msb] == 1'b0) msb--;
    m = 64'(p) << (30 - msb);
    fr = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        fr[0] = 1'b1;
      end
    end
    neg = (64'(PROB_BITS) << 16) - ((64'(msb) << 16) | fr);
    l = (neg * 64'(LN2_Q30) + (64'd1 << 29)) >> 30;
    return (l > 64'(LOSS_MAX)) ? 64'(LOSS_MAX) : l;
  endfunction

  function automatic logic [15:0] class_grad(input logic [31:0] p, input bit hot,
                                             input logic [31:0] bsz);
    longint diff, num;
    logic [63:0] mag, den, q;
    bit neg;
    diff = longint'(p) - (hot ? (longint'(1) << PROB_BITS) : 0);
    num = longint'(upstream_reg) * diff;
    neg = num < 0;
    mag = neg ? 64'(-num) : 64'(num);
    den = 64'(bsz) << (PROB_BITS - 3);
    q = (mag + den / 2) / den;
    if (neg) return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
    return (q > 32767) ? 16'h7fff : 16'(q);
  endfunction

  task automatic predict_item(input in_t it);
    logic signed [15:0] mx;
    logic [63:0] e [NCLS];
    logic [63:0] esum, rloss, mean, p;
    logic [31:0] probs [NCLS];
    logic [31:0] bsz;
    bit tgt_ok, mvalid;
    int n;
    out_t o;
    if (nlogits < NCLS) begin
      row_logits[nlogits] = it.logit;
      nlogits++;
    end else too_long = 1'b1;
    if (!it.last_in_row) return;
    n = nlogits;
    mx = row_logits[0];
    for (int c = 1; c < n; c++) if (row_logits[c] > mx) mx = row_logits[c];
    esum = 0;
    for (int c = 0; c < n; c++) begin
      e[c] = exp_q30(32'(int'(mx) - int'(row_logits[c])));
      esum += e[c];
    end
    for (int c = 0; c < n; c++) begin
      p = ((e[c] << PROB_BITS) + esum / 2) / esum;
      probs[c] = (p > 64'hffff) ? 32'hffff : 32'(p);
    end
    tgt_ok = it.target_class < n;
    rloss = 0;
    mean = 0;
    mvalid = 0;
    if (tgt_ok) begin
      rloss = loss_of_prob(probs[it.target_class]);
      if (64'(sum_loss) + rloss > 64'(SUM_MAX)) sum_loss = SUM_MAX;
      else sum_loss = sum_loss + 40'(rloss);
    end
    bsz = (batch_reg == 0) ? 1 : 32'(batch_reg);
    rows_in_batch++;
    if (32'(rows_in_batch) >= bsz) begin
      mean = (64'(sum_loss) + bsz / 2) / bsz;
      if (mean > 64'(LOSS_MAX)) mean = 64'(LOSS_MAX);
      mvalid = 1;
      sum_loss = 0;
      rows_in_batch = 0;
    end
    for (int c = 0; c < n; c++) begin
      o.gradient = class_grad(probs[c], tgt_ok && c == it.target_class, bsz);
      o.class_index = 5'(c);
      o.row_loss = 24'(rloss);
      o.mean_loss = 24'(mean);
      o.mean_valid = mvalid;
      o.last_of_row = (c + 1 == n);
      o.status = !tgt_ok ? STATUS_BAD_TARGET : (too_long ? STATUS_ROW_LONG : STATUS_OK);
      grad_queue.push_back(o);
    end
    nlogits = 0;
    too_long = 0;
    rows_sent++;
  endtask

  // output side: random stall, compare on transfer
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (grad_queue.size() == 0) report("unexpected", out_data_o, '0);
        else begin
          want = grad_queue.pop_front();
          if (out_data_o.gradient !== want.gradient) report("gradient", out_data_o, want);
          if (out_data_o.class_index !== want.class_index)
            report("class_index", out_data_o, want);
          if (out_data_o.row_loss !== want.row_loss) report("row_loss", out_data_o, want);
          if (out_data_o.mean_loss !== want.mean_loss) report("mean_loss", out_data_o, want);
          if (out_data_o.mean_valid !== want.mean_valid)
            report("mean_valid", out_data_o, want);
          if (out_data_o.last_of_row !== want.last_of_row)
            report("last_of_row", out_data_o, want);
          if (out_data_o.status !== want.status) report("status", out_data_o, want);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout");
      $display("FAIL");
      $finish;
    end
  end

  // valid stays high between back-to-back transfers; drop it only while idling
  task automatic send_item(input in_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_item(it);
    items_sent++;
  endtask

  task automatic drain(input int settle);
    in_valid_i <= 1'b0;
    while (grad_queue.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_BATCH_SIZE) batch_reg = val;
    else upstream_reg = val;
  endtask

  // random row: length mostly short, sometimes longer up to full, a single logit, or too long
  task automatic random_row(input int mode);
    int len, sel;
    in_t it;
    sel = $urandom_range(99);
    len = (sel < 70) ? $urandom_range(2, 8) : (sel < 90) ? $urandom_range(9, 32)
        : (sel < 96) ? 1 : $urandom_range(33, 36);
    for (int i = 0; i < len; i++) begin
      it.logit = (mode == 0) ? 16'($urandom_range(0, 16'hffff))
               : 16'(int'($urandom_range(0, 8000)) - 4000);
      it.last_in_row = (i == len - 1);
      it.target_class = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                      : 5'($urandom_range((len > 32 ? 32 : len) - 1));
      send_item(it);
    end
  endtask

  // directed rows: logit, target, last, and whether the row's loss is
  // known up front (target out of range gives loss zero)
  typedef struct {
    logic signed [15:0] logit;
    logic [4:0] tgt;
    bit last;
    bit check_zero_loss;
  } dir_row_t;

  dir_row_t dir_rows[15] = '{
    '{16'sh7fff, 5'd0, 0, 0}, '{-16'sh8000, 5'd1, 1, 0},
    '{-16'sh8000, 5'd0, 0, 0}, '{16'sh7fff, 5'd0, 1, 0},
    '{16'sh0000, 5'd0, 0, 0}, '{16'sh0000, 5'd0, 0, 0}, '{16'sh0000, 5'd2, 1, 0},
    '{16'sh0100, 5'd31, 0, 0}, '{16'sh0200, 5'd31, 1, 1},
    '{16'sh1234, 5'd0, 1, 0},
    '{16'sh0800, 5'd2, 0, 0}, '{-16'sh0800, 5'd2, 1, 1},
    '{16'sh5555, 5'd1, 0, 0}, '{16'shaaaa, 5'd1, 0, 0}, '{16'sh0001, 5'd1, 1, 0}
  };

  initial begin
    in_t it;
    int zero_loss_checks;
    for (int i = 0; i < NCLS; i++) row_logits[i] = '0;
    nlogits = 0;
    too_long = 0;
    sum_loss = 0;
    rows_in_batch = 0;
    batch_reg = 1;
    upstream_reg = 16'sd256;
    zero_loss_checks = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      it.logit = dir_rows[i].logit;
      it.target_class = dir_rows[i].tgt;
      it.last_in_row = dir_rows[i].last;
      send_item(it);
      // bad target row: predicted loss must be zero, status out of range
      if (dir_rows[i].check_zero_loss) begin
        zero_loss_checks++;
        if (grad_queue[$].row_loss != 0 || grad_queue[$].status != STATUS_BAD_TARGET) begin
          report("out-of-range target row", grad_queue[$], '0);
        end
      end
    end
    // full row plus overflow
    for (int i = 0; i < 34; i++) begin
      it.logit = 16'(i * 97);
      it.target_class = 5'd31;
      it.last_in_row = (i == 33);
      send_item(it);
    end
    drain(300);

    write_reg(REG_BATCH_SIZE, 16'd0);
    write_reg(REG_UPSTREAM, 16'h7fff);
    random_row(1);
    random_row(0);
    drain(300);
    write_reg(REG_UPSTREAM, 16'h8000);
    write_reg(REG_BATCH_SIZE, 16'hffff);
    random_row(1);
    random_row(1);
    drain(300);
    write_reg(REG_BATCH_SIZE, 16'd3);
    write_reg(REG_UPSTREAM, 16'hff00);
    random_row(1);
    drain(300);
    // lower the batch size to 1 at a batch boundary
    write_reg(REG_BATCH_SIZE, 16'd1);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 28 : (ph == 1) ? 80 : 0;
      recv_idle = (ph == 0) ? 80 : (ph == 1) ? 28 : 0;
      for (int k = 0; k < 80; k += 0) begin
        int before_items;
        before_items = items_sent;
        random_row($urandom_range(3) != 0);
        k += items_sent - before_items;
        if ($urandom_range(15) == 0) drain(0);
      end
      drain(300);
      write_reg(REG_BATCH_SIZE, 16'($urandom_range(1, 6)));
      write_reg(REG_UPSTREAM, 16'($urandom_range(0, 16'hffff)));
    end
    drain(300);

    $display("sent %0d logits in %0d rows, checked %0d gradients, %0d known-loss rows",
             items_sent, rows_sent, results_seen, zero_loss_checks);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> softmax_cross_entropy_loss_grad.f
src/sce_pkg.sv
src/sce_div.sv
src/sce_front.sv
src/sce_back.sv
src/softmax_cross_entropy_loss_grad.sv
tb/tb.sv
